@@ hdl/sprite_scanline_evaluation_assert.svh @@
// Assertion macros shared by the sprite evaluation RTL.
`ifndef SPRITE_SCANLINE_EVALUATION_ASSERT_SVH
`define SPRITE_SCANLINE_EVALUATION_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sse_pkg.sv @@
package sse_pkg;

  localparam int SPRITE_ENTRIES = 64;
  localparam int MAX_SELECTED   = 16;

  // Sprite memory is 256 bytes held as four byte lanes of 64 rows.
  localparam int MEM_ROWS = 64;
  localparam int ROW_W    = $clog2(MEM_ROWS);
  localparam int SEL_W    = $clog2(MAX_SELECTED);

  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(MEM_ROWS - 1);
  localparam logic [5:0]       SCAN_LAST = 6'(SPRITE_ENTRIES - 1);

  localparam logic [1:0] LANE_Y    = 2'd0;
  localparam logic [1:0] LANE_TILE = 2'd1;
  localparam logic [1:0] LANE_ATTR = 2'd2;
  localparam logic [1:0] LANE_X    = 2'd3;

  localparam logic [7:0] ATTR_MASK  = 8'he3;
  localparam logic [7:0] CLEAR_BYTE = 8'hff;

  localparam logic [4:0] LIMIT_MIN   = 5'd8;
  localparam logic [4:0] LIMIT_MAX   = 5'(MAX_SELECTED);
  localparam logic [4:0] OVF_COUNT   = 5'd8;
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  localparam logic CFG_TALL  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_SET_PTR = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2,
    OP_EVAL    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [8:0] scanline_number;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       found;
    logic [5:0] sprite_index;
    logic [7:0] sprite_y;
    logic [7:0] sprite_tile;
    logic [7:0] sprite_attr;
    logic [7:0] sprite_x;
    logic [4:0] selected_count;
    logic       overflow;
    logic       last;
  } result_t;

  // Program steps of the sequencer.
  typedef enum logic [3:0] {
    S_CLEAR    = 4'd0,
    S_IDLE     = 4'd1,
    S_RD_ISSUE = 4'd2,
    S_RD_OUT   = 4'd3,
    S_EV_INIT  = 4'd4,
    S_EV_SCAN  = 4'd5,
    S_EM_INIT  = 4'd6,
    S_EM_LOOP  = 4'd7,
    S_EM_NONE  = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    J_NEXT,        // step + 1
    J_GOTO,        // target
    J_DISPATCH,    // branch on accepted read or evaluate, else hold
    J_WAIT_CLEAR,  // target when clear sweep ends, else hold
    J_WAIT_SCAN,   // target when scan ends, else hold
    J_IF_NONE,     // target when nothing selected, else step + 1
    J_WAIT_LAST    // target on final emitted word, else hold
  } jump_t;

  typedef enum logic [1:0] {
    RA_PTR,
    RA_SCAN,
    RA_SEL
  } rsel_t;

  typedef struct packed {
    jump_t jump;
    step_t target;
    logic  busy;
    rsel_t rsel;
    logic  clear;
    logic  eval_init;
    logic  scan;
    logic  emit_init;
    logic  emit;
    logic  emit_none;
    logic  read_out;
  } uword_t;

  function automatic uword_t uw(jump_t j, step_t t, logic b, rsel_t r,
                                logic [6:0] act);
    uword_t w;
    w.jump      = j;
    w.target    = t;
    w.busy      = b;
    w.rsel      = r;
    w.clear     = act[6];
    w.eval_init = act[5];
    w.scan      = act[4];
    w.emit_init = act[3];
    w.emit      = act[2];
    w.emit_none = act[1];
    w.read_out  = act[0];
    return w;
  endfunction

  // Control store. Action bits: clear, eval_init, scan, emit_init, emit,
  // emit_none, read_out.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      S_CLEAR:    w = uw(J_WAIT_CLEAR, S_IDLE,    1'b1, RA_PTR,  7'b1000000);
      S_IDLE:     w = uw(J_DISPATCH,   S_IDLE,    1'b0, RA_PTR,  7'b0000000);
      S_RD_ISSUE: w = uw(J_NEXT,       S_IDLE,    1'b1, RA_PTR,  7'b0000000);
      S_RD_OUT:   w = uw(J_GOTO,       S_IDLE,    1'b1, RA_PTR,  7'b0000001);
      S_EV_INIT:  w = uw(J_NEXT,       S_IDLE,    1'b1, RA_SCAN, 7'b0100000);
      S_EV_SCAN:  w = uw(J_WAIT_SCAN,  S_EM_INIT, 1'b1, RA_SCAN, 7'b0010000);
      S_EM_INIT:  w = uw(J_IF_NONE,    S_EM_NONE, 1'b1, RA_SEL,  7'b0001000);
      S_EM_LOOP:  w = uw(J_WAIT_LAST,  S_IDLE,    1'b1, RA_SEL,  7'b0000100);
      S_EM_NONE:  w = uw(J_GOTO,       S_IDLE,    1'b1, RA_PTR,  7'b0000010);
      default:    w = uw(J_GOTO,       S_IDLE,    1'b1, RA_PTR,  7'b0000000);
    endcase
    return w;
  endfunction

  function automatic logic [4:0] clamp_limit(logic [4:0] v);
    logic [4:0] r;
    if (v < LIMIT_MIN) r = LIMIT_MIN;
    else if (v > LIMIT_MAX) r = LIMIT_MAX;
    else r = v;
    return r;
  endfunction

endpackage

@@ hdl/sse_ram.sv @@
module sse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sprite_scanline_evaluation.sv @@
// Channel   Ports                           Handshake
// command   cmd (cmd_t)                     taken when start && !busy
// result    result (result_t)               one word per cycle with result_strobe
// config    cfg_we, cfg_index, cfg_data     written when cfg_we, no wait
//
// Set pointer and write byte finish in the cycle they are taken.
// Read byte: the row is read in the issue step and the result word comes out in the
// output step, busy high through both. Evaluate: one sprite entry per cycle through
// the scan step, then a setup step and one result word per selected sprite (one
// word if none). Busy stays high until the final word has gone.
// After reset a sweep writes 0xff over all 64 memory rows (busy high).
// The receiver cannot stall: every result word is taken in its strobe cycle.
`include "sprite_scanline_evaluation_assert.svh"

module sprite_scanline_evaluation (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sse_pkg::cmd_t    cmd,
  output sse_pkg::result_t result,
  output logic             result_strobe,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [4:0]       cfg_data
);

  // Sequencer state and control word.
  sse_pkg::step_t  pc;
  sse_pkg::step_t  pc_next;
  sse_pkg::uword_t uw;

  // Configuration.
  logic       tall;
  logic [4:0] limit;

  // Datapath registers.
  logic [7:0]                    ptr;
  logic [sse_pkg::ROW_W-1:0]     clr_cnt;
  logic [8:0]                    line;
  logic [5:0]                    scan_addr;
  logic [5:0]                    chk_idx;
  logic                          chk_valid;
  logic [4:0]                    count;
  logic                          ovf;
  logic [5:0]                    sel_buf [sse_pkg::MAX_SELECTED];
  logic [5:0]                    cur_idx;
  logic [4:0]                    rp;

  logic accept;
  logic wr_cmd;

  // Memory ports.
  logic [3:0]                lane_we;
  logic [sse_pkg::ROW_W-1:0] waddr;
  logic [7:0]                wdata;
  logic [sse_pkg::ROW_W-1:0] raddr;
  logic [7:0]                lane_rdata [4];

  // Scan compare.
  logic [9:0]                diff;
  logic                      hit;
  logic                      take;
  logic                      set_ovf;
  logic                      scan_break;
  logic                      scan_done;
  logic [sse_pkg::SEL_W-1:0] sel_rd;
  logic [5:0]                sel_idx;
  logic                      emit_last;
  logic [7:0]                rd_byte;

  assign accept = start && !busy;
  assign wr_cmd = accept && (sse_pkg::op_t'(cmd.operation) == sse_pkg::OP_WRITE);

  // ---------------------------------------------------------------- control
  always_comb begin
    uw   = sse_pkg::ucode(pc);
    busy = uw.busy;
  end

  always_comb begin
    pc_next = pc;
    unique case (uw.jump)
      sse_pkg::J_NEXT:  pc_next = sse_pkg::step_t'(pc + 4'd1);
      sse_pkg::J_GOTO:  pc_next = uw.target;
      sse_pkg::J_DISPATCH: begin
        if (accept) begin
          unique case (sse_pkg::op_t'(cmd.operation))
            sse_pkg::OP_READ:    pc_next = sse_pkg::S_RD_ISSUE;
            sse_pkg::OP_EVAL:    pc_next = sse_pkg::S_EV_INIT;
            sse_pkg::OP_SET_PTR,
            sse_pkg::OP_WRITE:   pc_next = pc;
          endcase
        end
      end
      sse_pkg::J_WAIT_CLEAR: if (clr_cnt == sse_pkg::ROW_LAST) pc_next = uw.target;
      sse_pkg::J_WAIT_SCAN:  if (scan_done) pc_next = uw.target;
      sse_pkg::J_IF_NONE: begin
        if (count == 5'd0) pc_next = uw.target;
        else pc_next = sse_pkg::step_t'(pc + 4'd1);
      end
      sse_pkg::J_WAIT_LAST:  if (emit_last) pc_next = uw.target;
      default:               pc_next = sse_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sse_pkg::S_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tall  <= 1'b0;
      limit <= sse_pkg::clamp_limit(sse_pkg::LIMIT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sse_pkg::CFG_TALL:  tall  <= cfg_data[0];
        sse_pkg::CFG_LIMIT: limit <= sse_pkg::clamp_limit(cfg_data);
      endcase
    end
  end

  // ------------------------------------------------------- sprite memory
  // Four byte lanes: row = pointer[7:2], lane = pointer[1:0]. A whole entry
  // comes out of one row read.
  assign waddr = uw.clear ? clr_cnt : ptr[7:2];
  assign wdata = uw.clear ? sse_pkg::CLEAR_BYTE : cmd.data_byte;

  assign sel_rd  = uw.emit_init ? '0 : rp[sse_pkg::SEL_W-1:0];
  assign sel_idx = sel_buf[sel_rd];

  always_comb begin
    unique case (uw.rsel)
      sse_pkg::RA_PTR:  raddr = ptr[7:2];
      sse_pkg::RA_SCAN: raddr = sse_pkg::ROW_W'(scan_addr);
      sse_pkg::RA_SEL:  raddr = sse_pkg::ROW_W'(sel_idx);
      default:          raddr = ptr[7:2];
    endcase
  end

  for (genvar ln = 0; ln < 4; ln++) begin : g_lane
    assign lane_we[ln] = uw.clear || (wr_cmd && (ptr[1:0] == 2'(ln)));

    sse_ram #(
      .WIDTH(8),
      .DEPTH(sse_pkg::MEM_ROWS)
    ) u_lane (
      .clk  (clk),
      .we   (lane_we[ln]),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(lane_rdata[ln])
    );
  end

  // ------------------------------------------------------------ host access
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= 8'd0;
      clr_cnt <= '0;
    end else begin
      if (uw.clear) clr_cnt <= clr_cnt + sse_pkg::ROW_W'(1);
      if (accept && (sse_pkg::op_t'(cmd.operation) == sse_pkg::OP_SET_PTR)) begin
        ptr <= cmd.data_byte;
      end else if (wr_cmd) begin
        ptr <= ptr + 8'd1;
      end
    end
  end

  // ------------------------------------------------------------------- scan
  // A row is issued one cycle and compared the next, so the scan runs one
  // entry per cycle. Difference is taken wide enough to see line < y.
  assign diff = {1'b0, line} - {2'b00, lane_rdata[sse_pkg::LANE_Y]};
  assign hit  = chk_valid && !diff[9] && (diff[8:4] == 5'd0) && (tall || !diff[3]);

  always_comb begin
    set_ovf    = hit && (count == sse_pkg::OVF_COUNT);
    take       = hit && !(set_ovf && (limit == sse_pkg::LIMIT_MIN)) && (count < limit);
    scan_break = (set_ovf && (limit == sse_pkg::LIMIT_MIN))
              || (take && ((count + 5'd1) == limit) && (limit != sse_pkg::LIMIT_MIN));
    scan_done  = scan_break || (chk_valid && (chk_idx == sse_pkg::SCAN_LAST));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 5'd0;
      ovf       <= 1'b0;
      chk_valid <= 1'b0;
      rp        <= 5'd0;
    end else begin
      if (uw.eval_init) begin
        count     <= 5'd0;
        ovf       <= 1'b0;
        chk_valid <= 1'b0;
      end else if (uw.scan) begin
        chk_valid <= 1'b1;
        if (set_ovf) ovf <= 1'b1;
        if (take) count <= count + 5'd1;
      end
      if (uw.emit_init) rp <= 5'd1;
      else if (uw.emit) rp <= rp + 5'd1;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (accept) line <= cmd.scanline_number;
    if (uw.eval_init) begin
      scan_addr <= 6'd0;
    end else if (uw.scan) begin
      scan_addr <= scan_addr + 6'd1;
      chk_idx   <= scan_addr;
      if (take) sel_buf[count[sse_pkg::SEL_W-1:0]] <= chk_idx;
    end
    // Hold the entry number of the row now being read.
    if (uw.emit_init || uw.emit) cur_idx <= sel_idx;
  end

  // ----------------------------------------------------------------- output
  assign emit_last = (rp == count);
  assign rd_byte   = (ptr[1:0] == sse_pkg::LANE_ATTR)
                   ? (lane_rdata[ptr[1:0]] & sse_pkg::ATTR_MASK)
                   : lane_rdata[ptr[1:0]];

  always_comb begin
    result        = '0;
    result_strobe = uw.read_out || uw.emit || uw.emit_none;
    if (uw.read_out) begin
      result.read_data = rd_byte;
      result.last      = 1'b1;
    end else if (uw.emit) begin
      result.found          = 1'b1;
      result.sprite_index   = cur_idx;
      result.sprite_y       = lane_rdata[sse_pkg::LANE_Y];
      result.sprite_tile    = lane_rdata[sse_pkg::LANE_TILE];
      result.sprite_attr    = lane_rdata[sse_pkg::LANE_ATTR];
      result.sprite_x       = lane_rdata[sse_pkg::LANE_X];
      result.selected_count = rp;
      result.overflow       = ovf;
      result.last           = emit_last;
    end else if (uw.emit_none) begin
      result.overflow = ovf;
      result.last     = 1'b1;
    end
  end

  // ------------------------------------------------------------- assertions
  `SSE_ASSERT_SAME(a_strobe_busy, clk, rst, result_strobe, busy,
    "result word outside a busy period")
  `SSE_ASSERT_NEXT(a_eval_busy, clk, rst,
    accept && (cmd.operation == 2'(sse_pkg::OP_EVAL)), busy,
    "evaluation taken but block not busy")
  `SSE_ASSERT_SAME(a_ovf_count, clk, rst, ovf, count >= sse_pkg::OVF_COUNT,
    "overflow set with fewer than eight selected")
  `SSE_ASSERT_SAME(a_found_count, clk, rst, result_strobe && result.found,
    (result.selected_count != 5'd0) && (result.selected_count <= count),
    "selected sprite word carries a bad count")

endmodule
